[hw/rtl/case_insensitive_edit_distance_unit_macros.svh]
// Assertion helpers for the checker file.
`ifndef CASE_INSENSITIVE_EDIT_DISTANCE_UNIT_MACROS_SVH
`define CASE_INSENSITIVE_EDIT_DISTANCE_UNIT_MACROS_SVH

// Property checked every clock, masked while reset is high.
`define CIED_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
   else $error(msg);

// Property checked every clock, reset included.
`define CIED_ASSERT_NR(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) \
   else $error(msg);

`endif

[hw/rtl/cied_pkg.sv]
package cied_pkg;

   localparam int CHAR_W = 8;
   localparam int DIST_W = 9;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_FETCH = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   // ASCII upper case to lower case, other bytes pass unchanged
   function automatic logic [CHAR_W-1:0] fold_byte(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

[hw/rtl/cied_cell.sv]
// One DP cell: min(up + 1, left + 1, diag + mismatch)
module cied_cell
   import cied_pkg::*;
#(
   parameter int DW = 9
) (
   input  logic [DW-1:0]     up,
   input  logic [DW-1:0]     left,
   input  logic [DW-1:0]     diag,
   input  logic [CHAR_W-1:0] q_char,
   input  logic [CHAR_W-1:0] c_char,
   output logic [DW-1:0]     best
);

   logic [DW:0] up_p1;
   logic [DW:0] left_p1;
   logic [DW:0] diag_c;
   logic [DW:0] m1;
   logic [DW:0] m2;
   logic        miss;

   always_comb begin
      miss    = (fold_byte(q_char) != fold_byte(c_char));
      up_p1   = {1'b0, up} + (DW+1)'(1);
      left_p1 = {1'b0, left} + (DW+1)'(1);
      diag_c  = {1'b0, diag} + (DW+1)'(miss);
      m1      = (left_p1 < up_p1) ? left_p1 : up_p1;
      m2      = (diag_c < m1) ? diag_c : m1;
      // a cell never exceeds the longer string length, so the top bit drops
      best    = m2[DW-1:0];
   end

endmodule

[hw/rtl/case_insensitive_edit_distance_unit.sv]
// Case-insensitive Levenshtein distance between a loaded query and a streamed
// candidate. Query items (req_type 0) are stored while the unit stays idle. A
// candidate item with a character sweeps one DP row through a single shared
// cell unit, one cell per cycle over the row store's read and write port.
// After the last candidate item, the FETCH state reads the final cell and the
// EMIT state loads the result register; a result may wait there while the
// next item is taken. No clearing pass is needed after reset: the first row
// of each candidate is taken as 0..query_length by a flag instead of a
// memory fill. Strings longer than MAX_LEN give too_long with distance 0.
module case_insensitive_edit_distance_unit
   import cied_pkg::*;
#(
   parameter int MAX_LEN = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_type,
   input  logic [CHAR_W-1:0] req_char_byte,
   input  logic              req_has_char,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DIST_W-1:0] rsp_distance,
   output logic              rsp_too_long
);

   localparam int LW  = $clog2(MAX_LEN + 1);
   localparam int QAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   localparam logic [LW-1:0] MAX_L = LW'(MAX_LEN);
   localparam logic [LW-1:0] ONE_L = LW'(1);

   // storage
   logic [CHAR_W-1:0] qmem [0:MAX_LEN-1];
   logic [LW-1:0]     rmem [0:MAX_LEN];

   state_type         state_ff, state_in;
   logic [LW-1:0]     qlen_ff, qlen_in;
   logic              qovf_ff, qovf_in;
   logic              qdone_ff, qdone_in;
   logic [LW-1:0]     clen_ff, clen_in;
   logic              covf_ff, covf_in;
   logic              act_ff, act_in;
   logic              fresh_ff, fresh_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic              last_ff, last_in;
   logic [LW-1:0]     rj_ff, rj_in;
   logic              iss_ff, iss_in;
   logic              pv_ff, pv_in;
   logic [LW-1:0]     pj_ff, pj_in;
   logic [LW-1:0]     diag_ff, diag_in;
   logic [LW-1:0]     left_ff, left_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic              rsp_tl_ff, rsp_tl_in;

   logic [LW-1:0]     row_rd_ff;
   logic [CHAR_W-1:0] q_rd_ff;

   logic              q_we;
   logic [QAW-1:0]    q_wa;
   logic [QAW-1:0]    q_ra;
   logic              r_we;
   logic [LW-1:0]     r_wa;
   logic [LW-1:0]     r_wd;
   logic [LW-1:0]     r_ra;
   logic [LW-1:0]     rj_m1;

   logic              accept;
   logic [LW-1:0]     q_base;
   logic [LW-1:0]     c_base;
   logic [LW-1:0]     up;
   logic [LW-1:0]     cell_best;
   logic [LW-1:0]     final_dist;

   cied_cell #(.DW(LW)) u_cell (
      .up     (up),
      .left   (left_ff),
      .diag   (diag_ff),
      .q_char (q_rd_ff),
      .c_char (ch_ff),
      .best   (cell_best)
   );

   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_dist_ff;
   assign rsp_too_long = rsp_tl_ff;

   assign rj_m1  = rj_ff - ONE_L;
   assign q_ra   = rj_m1[QAW-1:0];
   assign r_ra   = (state_ff == ST_RUN) ? rj_ff : qlen_ff;
   // first row of a candidate is implicit: cell j holds j
   assign up     = fresh_ff ? pj_ff : row_rd_ff;
   assign q_base = qdone_ff ? '0 : qlen_ff;
   assign c_base = act_ff ? clen_ff : '0;
   assign final_dist = fresh_ff ? qlen_ff : row_rd_ff;

   always_comb begin
      state_in     = state_ff;
      qlen_in      = qlen_ff;
      qovf_in      = qovf_ff;
      qdone_in     = qdone_ff;
      clen_in      = clen_ff;
      covf_in      = covf_ff;
      act_in       = act_ff;
      fresh_in     = fresh_ff;
      ch_in        = ch_ff;
      last_in      = last_ff;
      rj_in        = rj_ff;
      iss_in       = iss_ff;
      pv_in        = 1'b0;
      pj_in        = pj_ff;
      diag_in      = diag_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_dist_in  = rsp_dist_ff;
      rsp_tl_in    = rsp_tl_ff;
      q_we         = 1'b0;
      q_wa         = q_base[QAW-1:0];
      r_we         = 1'b0;
      r_wa         = pj_ff;
      r_wd         = cell_best;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !req_type) begin
               // query byte; a query item also drops any open candidate
               act_in   = 1'b0;
               qlen_in  = q_base;
               qovf_in  = qdone_ff ? 1'b0 : qovf_ff;
               qdone_in = req_last;
               if (req_has_char) begin
                  if (q_base < MAX_L) begin
                     q_we    = 1'b1;
                     qlen_in = q_base + ONE_L;
                  end else begin
                     qovf_in = 1'b1;
                  end
               end
            end else if (accept) begin
               act_in   = 1'b1;
               clen_in  = c_base;
               covf_in  = act_ff ? covf_ff : 1'b0;
               fresh_in = act_ff ? fresh_ff : 1'b1;
               ch_in    = req_char_byte;
               last_in  = req_last;
               if (req_has_char && c_base < MAX_L) begin
                  clen_in  = c_base + ONE_L;
                  rj_in    = '0;
                  iss_in   = 1'b1;
                  state_in = ST_RUN;
               end else begin
                  if (req_has_char) begin
                     covf_in = 1'b1;
                  end
                  if (req_last) begin
                     act_in   = 1'b0;
                     state_in = ST_FETCH;
                  end
               end
            end
         end
         ST_RUN: begin
            // read side: one cell address per cycle
            if (iss_ff) begin
               pv_in = 1'b1;
               pj_in = rj_ff;
               rj_in = rj_ff + ONE_L;
               if (rj_ff == qlen_ff) begin
                  iss_in = 1'b0;
               end
            end
            // compute and write back side
            if (pv_ff) begin
               r_we    = 1'b1;
               diag_in = up;
               if (pj_ff == '0) begin
                  r_wd    = clen_ff;
                  left_in = clen_ff;
               end else begin
                  left_in = cell_best;
               end
               if (pj_ff == qlen_ff) begin
                  fresh_in = 1'b0;
                  if (last_ff) begin
                     act_in   = 1'b0;
                     state_in = ST_FETCH;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_tl_in    = qovf_ff || covf_ff;
               rsp_dist_in  = (qovf_ff || covf_ff) ? '0 : DIST_W'(final_dist);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         qlen_ff      <= '0;
         qovf_ff      <= 1'b0;
         qdone_ff     <= 1'b1;
         clen_ff      <= '0;
         covf_ff      <= 1'b0;
         act_ff       <= 1'b0;
         fresh_ff     <= 1'b0;
         iss_ff       <= 1'b0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         qlen_ff      <= qlen_in;
         qovf_ff      <= qovf_in;
         qdone_ff     <= qdone_in;
         clen_ff      <= clen_in;
         covf_ff      <= covf_in;
         act_ff       <= act_in;
         fresh_ff     <= fresh_in;
         iss_ff       <= iss_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      last_ff     <= last_in;
      rj_ff       <= rj_in;
      pj_ff       <= pj_in;
      diag_ff     <= diag_in;
      left_ff     <= left_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_tl_ff   <= rsp_tl_in;
   end

   // query store
   always_ff @(posedge clock) begin
      if (q_we) begin
         qmem[q_wa] <= req_char_byte;
      end
      q_rd_ff <= qmem[q_ra];
   end

   // row store; write and read never hit the same cell in one cycle
   always_ff @(posedge clock) begin
      if (r_we) begin
         rmem[r_wa] <= r_wd;
      end
      row_rd_ff <= rmem[r_ra];
   end

endmodule

[hw/rtl/cied_checker.sv]
`include "case_insensitive_edit_distance_unit_macros.svh"

module cied_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_type,
   input logic       req_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [8:0] rsp_distance,
   input logic       rsp_too_long
);

   `CIED_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped before transfer")

   `CIED_ASSERT(a_too_long_zero, clock, reset, rsp_valid && rsp_too_long |-> rsp_distance == 9'd0, "too_long result with nonzero distance")

   `CIED_ASSERT(a_last_busy, clock, reset, req_valid && req_ready && req_type && req_last |=> !req_ready, "input still open after final candidate transfer")

   `CIED_ASSERT_NR(a_reset_quiet, clock, reset |=> !rsp_valid, "result valid right after reset")

endmodule

bind case_insensitive_edit_distance_unit cied_checker u_cied_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .req_type     (req_type),
   .req_last     (req_last),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_distance (rsp_distance),
   .rsp_too_long (rsp_too_long)
);
